// ----- rtl/assert_macros.svh -----
// Assertion macros used by the rate table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CHK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rate table assertion failed");
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("rate table assertion failed");
`else
`define ASSERT_CHK(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- rtl/cfrt_pkg.sv -----
// Types and constants of the client flow rate table.
package cfrt_pkg;

    localparam int DATA_W      = 32;
    localparam int SLOT_W      = 5;
    localparam int COUNT_W     = 6;
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_FIELD_W = SLOT_W + 2 * DATA_W + COUNT_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;
    localparam int OUT_TUSER_W = 2;

    typedef enum logic [1:0] {
        OC_UPDATE  = 2'd0,
        OC_INSERT  = 2'd1,
        OC_REPLACE = 2'd2,
        OC_DROP    = 2'd3
    } t_outcome;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] last_rx;
        logic [DATA_W-1:0] last_tx;
        logic [DATA_W-1:0] rx_rate;
        logic [DATA_W-1:0] tx_rate;
    } t_entry;

endpackage

// ----- rtl/client_flow_rate_table_unit.sv -----
// Client flow rate table: key search, rate division and table write-back.
// Requests are taken one at a time, only while idle; each one scans the filled slots (up to
// the match on a hit, all of them on a miss), is decided, passes the divider and is registered.
// A dropped request skips the divider. The divider registers the dividends, the reciprocal
// product, the estimate with its remainder and the corrected quotient in turn.
// Reset clears the fill count, the state machine, the divider stages and the output valid only.
`include "assert_macros.svh"

module client_flow_rate_table_unit
    import cfrt_pkg::*;
#(
    parameter int MAX_CLIENTS = 32,
    parameter int INTERVAL    = 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // client_ip [31:0], rx_total [63:32], tx_total [95:64]
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // slot [4:0], rx_rate [36:5], tx_rate [68:37], client_count [74:69], zeros above
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    // outcome [1:0]
    output logic [OUT_TUSER_W-1:0] o_m_tuser
);

    localparam int AW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int CW = $clog2(MAX_CLIENTS + 1);
    localparam logic [CW-1:0] MAX_FILL = CW'(MAX_CLIENTS);

    t_state            r_state;
    t_state            n_state;
    logic [CW-1:0]     r_fill;
    logic [DATA_W-1:0] r_key;
    logic [DATA_W-1:0] r_rx;
    logic [DATA_W-1:0] r_tx;
    logic [AW-1:0]     r_idx;
    logic              r_found;
    logic              r_have_idle;
    logic [AW-1:0]     r_idle;
    logic [AW-1:0]     r_slot;
    t_outcome          r_outcome;
    t_entry            r_entry;
    logic [DATA_W-1:0] r_res_rx;
    logic [DATA_W-1:0] r_res_tx;
    logic              r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [OUT_TUSER_W-1:0] r_out_user;

    logic              w_in_fire;
    logic              w_hit;
    logic              w_last;
    logic              w_out_load;
    logic [AW-1:0]     w_raddr;
    t_entry            w_rd_data;
    logic              w_we;
    t_entry            w_wdata;
    t_outcome          w_outcome;
    logic [AW-1:0]     w_slot;
    logic              w_div_start;
    logic [DATA_W-1:0] w_dvd_rx;
    logic [DATA_W-1:0] w_dvd_tx;
    logic              w_div_done;
    logic [DATA_W-1:0] w_quo_rx;
    logic [DATA_W-1:0] w_quo_tx;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_in_fire  = i_s_tvalid && o_s_tready;
    assign w_hit      = (w_rd_data.key == r_key);
    assign w_last     = (CW'(r_idx) == (r_fill - CW'(1)));
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || i_m_tready);

    cfrt_mem #(
        .DEPTH (MAX_CLIENTS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_slot),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_data)
    );

    cfrt_div #(
        .DIVISOR (INTERVAL)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_dvd_a (w_dvd_rx),
        .i_dvd_b (w_dvd_tx),
        .o_done  (w_div_done),
        .o_quo_a (w_quo_rx),
        .o_quo_b (w_quo_tx)
    );

    always_comb begin
        if (r_found) begin
            w_outcome = OC_UPDATE;
            w_slot    = r_slot;
        end else if (r_fill < MAX_FILL) begin
            w_outcome = OC_INSERT;
            w_slot    = r_fill[AW-1:0];
        end else if (r_have_idle) begin
            w_outcome = OC_REPLACE;
            w_slot    = r_idle;
        end else begin
            w_outcome = OC_DROP;
            w_slot    = '0;
        end
        w_dvd_rx = r_found ? (r_rx - r_entry.last_rx) : r_rx;
        w_dvd_tx = r_found ? (r_tx - r_entry.last_tx) : r_tx;
    end

    always_comb begin
        w_wdata         = r_entry;
        w_wdata.key     = r_key;
        if (r_outcome != OC_UPDATE || r_rx != '0) begin
            w_wdata.rx_rate = w_quo_rx;
            w_wdata.last_rx = r_rx;
        end
        if (r_outcome != OC_UPDATE || r_tx != '0) begin
            w_wdata.tx_rate = w_quo_tx;
            w_wdata.last_tx = r_tx;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_raddr     = '0;
        w_div_start = 1'b0;
        w_we        = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = (r_fill == '0) ? S_DECIDE : S_SCAN;
                end
            end
            S_SCAN: begin
                w_raddr = r_idx + 1'b1;
                if (w_hit || w_last) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (w_outcome == OC_DROP) begin
                    n_state = S_OUT;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    w_we    = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_we && r_outcome == OC_INSERT) begin
                r_fill <= r_fill + 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_key       <= i_s_tdata[DATA_W-1:0];
            r_rx        <= i_s_tdata[2*DATA_W-1:DATA_W];
            r_tx        <= i_s_tdata[3*DATA_W-1:2*DATA_W];
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_have_idle <= 1'b0;
        end
        if (r_state == S_SCAN) begin
            if (w_hit) begin
                r_found <= 1'b1;
                r_slot  <= r_idx;
                r_entry <= w_rd_data;
            end else begin
                if (w_rd_data.rx_rate == '0 && w_rd_data.tx_rate == '0) begin
                    r_have_idle <= 1'b1;
                    r_idle      <= r_idx;
                end
                r_idx <= r_idx + 1'b1;
            end
        end
        if (r_state == S_DECIDE) begin
            r_slot    <= w_slot;
            r_outcome <= w_outcome;
            if (w_outcome == OC_DROP) begin
                r_res_rx <= '0;
                r_res_tx <= '0;
            end
        end
        if (w_we) begin
            r_res_rx <= w_wdata.rx_rate;
            r_res_tx <= w_wdata.tx_rate;
        end
        if (w_out_load) begin
            r_out_data <= {{OUT_PAD_W{1'b0}}, COUNT_W'(r_fill), r_res_tx, r_res_rx,
                           SLOT_W'(r_slot)};
            r_out_user <= r_outcome;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    `ASSERT_CHK(a_fill_bound, i_clk, i_rst_n, r_fill <= MAX_FILL)
    `ASSERT_CHK(a_insert_grows, i_clk, i_rst_n,
                (w_we && r_outcome == OC_INSERT) |=> (r_fill == $past(r_fill) + 1'b1))
    `ASSERT_CHK(a_div_done_in_div, i_clk, i_rst_n, w_div_done |-> (r_state == S_DIV))
    `ASSERT_CHK(a_scan_in_range, i_clk, i_rst_n, (r_state == S_SCAN) |-> (CW'(r_idx) < r_fill))
    `ASSERT_CHK(a_drop_slot_zero, i_clk, i_rst_n,
                (r_out_valid && r_out_user == OC_DROP) |-> (r_out_data[SLOT_W-1:0] == '0))

endmodule

// ----- rtl/cfrt_mem.sv -----
// Client table memory with one write port and one registered read port.
module cfrt_mem
    import cfrt_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/cfrt_div.sv -----
// Two-lane divider by a fixed interval, built from a reciprocal multiply and one correction.
module cfrt_div
    import cfrt_pkg::*;
#(
    parameter int DIVISOR = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_dvd_a,
    input  logic [DATA_W-1:0] i_dvd_b,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quo_a,
    output logic [DATA_W-1:0] o_quo_b
);

    localparam int PROD_W = 2 * DATA_W;
    localparam logic [DATA_W-1:0] RECIP =
        DATA_W'(((64'd1 << DATA_W) - 64'd1) / 64'(DIVISOR));
    localparam logic [DATA_W-1:0] DIV_C = DATA_W'(DIVISOR);

    logic [DATA_W-1:0] r_dvd  [2];
    logic [PROD_W-1:0] r_prod [2];
    logic [DATA_W-1:0] r_est  [2];
    logic [DATA_W-1:0] r_rem  [2];
    logic [DATA_W-1:0] r_quo  [2];
    logic [DATA_W-1:0] w_est  [2];
    logic [DATA_W-1:0] w_back [2];
    logic [3:0]        r_stage;

    // The estimate is the true quotient or one below it; the remainder test fixes it up.
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_est[l]  = r_prod[l][PROD_W-1:DATA_W];
            w_back[l] = w_est[l] * DIV_C;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else begin
            r_stage <= {r_stage[2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd[0] <= i_dvd_a;
            r_dvd[1] <= i_dvd_b;
        end
        for (int l = 0; l < 2; l++) begin
            r_prod[l] <= PROD_W'(r_dvd[l]) * PROD_W'(RECIP);
            r_est[l]  <= w_est[l];
            r_rem[l]  <= r_dvd[l] - w_back[l];
            r_quo[l]  <= (r_rem[l] >= DIV_C) ? r_est[l] + 1'b1 : r_est[l];
        end
    end

    assign o_done  = r_stage[3];
    assign o_quo_a = r_quo[0];
    assign o_quo_b = r_quo[1];

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the client flow rate table unit.
`timescale 1ns / 100ps

module testbench;
    import cfrt_pkg::*;

    localparam int MAX_CLIENTS = 32;
    localparam logic [DATA_W-1:0] RATE_INTERVAL = 2;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_PER_PHASE = 250;
    localparam int RX_LO = SLOT_W;
    localparam int TX_LO = SLOT_W + DATA_W;
    localparam int CNT_LO = SLOT_W + 2 * DATA_W;

    typedef struct {
        logic [SLOT_W-1:0]  slot;
        t_outcome           outcome;
        logic [DATA_W-1:0]  rx_rate;
        logic [DATA_W-1:0]  tx_rate;
        logic [COUNT_W-1:0] count;
    } t_client_rate;

    typedef enum {ROW_REQ, ROW_FILL} t_row_kind;

    typedef struct {
        t_row_kind         kind;
        logic [DATA_W-1:0] ip;
        logic [DATA_W-1:0] rx;
        logic [DATA_W-1:0] tx;
        bit                typed;
        t_client_rate      res;
    } t_stim_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic [OUT_TUSER_W-1:0] o_m_tuser;

    logic [DATA_W-1:0] tbl_key     [MAX_CLIENTS];
    logic [DATA_W-1:0] tbl_last_rx [MAX_CLIENTS];
    logic [DATA_W-1:0] tbl_last_tx [MAX_CLIENTS];
    logic [DATA_W-1:0] tbl_rx_rate [MAX_CLIENTS];
    logic [DATA_W-1:0] tbl_tx_rate [MAX_CLIENTS];
    int                tbl_fill = 0;

    t_client_rate pending_rates[$];
    t_stim_row    directed_rows[$];

    int fail_count = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int outcome_seen [4] = '{0, 0, 0, 0};
    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int hold_pending = 0;
    int stuck_cycles = 0;

    client_flow_rate_table_unit #(
        .MAX_CLIENTS(MAX_CLIENTS),
        .INTERVAL(int'(RATE_INTERVAL))
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata),
        .o_m_tuser(o_m_tuser)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void load_client(int s, logic [DATA_W-1:0] ip, rx, tx);
        tbl_key[s] = ip;
        tbl_last_rx[s] = rx;
        tbl_last_tx[s] = tx;
        tbl_rx_rate[s] = rx / RATE_INTERVAL;
        tbl_tx_rate[s] = tx / RATE_INTERVAL;
    endfunction

    function automatic t_client_rate rate_table_apply(logic [DATA_W-1:0] ip, rx, tx);
        t_client_rate res;
        int hit;
        int idle_slot;
        int take;
        hit = -1;
        idle_slot = -1;
        take = 0;
        for (int j = 0; j < tbl_fill && hit < 0; j++) begin
            if (tbl_key[j] == ip) begin
                hit = j;
            end else if (tbl_rx_rate[j] == 0 && tbl_tx_rate[j] == 0) begin
                idle_slot = j;
            end
        end
        res.outcome = OC_DROP;
        if (hit >= 0) begin
            if (rx != 0) begin
                tbl_rx_rate[hit] = DATA_W'(rx - tbl_last_rx[hit]) / RATE_INTERVAL;
                tbl_last_rx[hit] = rx;
            end
            if (tx != 0) begin
                tbl_tx_rate[hit] = DATA_W'(tx - tbl_last_tx[hit]) / RATE_INTERVAL;
                tbl_last_tx[hit] = tx;
            end
            take = hit;
            res.outcome = OC_UPDATE;
        end else if (tbl_fill < MAX_CLIENTS) begin
            take = tbl_fill;
            load_client(take, ip, rx, tx);
            tbl_fill++;
            res.outcome = OC_INSERT;
        end else if (idle_slot >= 0) begin
            take = idle_slot;
            load_client(take, ip, rx, tx);
            res.outcome = OC_REPLACE;
        end
        if (res.outcome == OC_DROP) begin
            res.slot = '0;
            res.rx_rate = '0;
            res.tx_rate = '0;
        end else begin
            res.slot = SLOT_W'(take);
            res.rx_rate = tbl_rx_rate[take];
            res.tx_rate = tbl_tx_rate[take];
        end
        res.count = COUNT_W'(tbl_fill);
        return res;
    endfunction

    function automatic t_client_rate make_result(int slot, t_outcome oc,
                                                 logic [DATA_W-1:0] rr, tr, int cnt);
        t_client_rate res;
        res.slot = SLOT_W'(slot);
        res.outcome = oc;
        res.rx_rate = rr;
        res.tx_rate = tr;
        res.count = COUNT_W'(cnt);
        return res;
    endfunction

    function automatic t_stim_row plain_row(logic [DATA_W-1:0] ip, rx, tx);
        t_stim_row r;
        r.kind = ROW_REQ;
        r.ip = ip;
        r.rx = rx;
        r.tx = tx;
        r.typed = 1'b0;
        r.res = make_result(0, OC_DROP, 0, 0, 0);
        return r;
    endfunction

    function automatic t_stim_row typed_row(logic [DATA_W-1:0] ip, rx, tx, int slot,
                                            t_outcome oc, logic [DATA_W-1:0] rr, tr,
                                            int cnt);
        t_stim_row r;
        r = plain_row(ip, rx, tx);
        r.typed = 1'b1;
        r.res = make_result(slot, oc, rr, tr, cnt);
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] counter_near(logic [DATA_W-1:0] last);
        case ($urandom_range(6))
            0: return '0;
            1: return last;
            2: return last + $urandom_range(1, 4000);
            3: return last - $urandom_range(1, 4000);
            4: return $urandom;
            5: return '1;
            default: return last + 1;
        endcase
    endfunction

    task automatic next_random_request(output logic [DATA_W-1:0] ip, rx, tx);
        int pick;
        int k;
        pick = $urandom_range(99);
        k = $urandom_range(tbl_fill - 1);
        if (pick < 50) begin
            ip = tbl_key[k];
            rx = counter_near(tbl_last_rx[k]);
            tx = counter_near(tbl_last_tx[k]);
        end else if (pick < 62) begin
            ip = tbl_key[k];
            rx = tbl_last_rx[k] + $urandom_range(1);
            tx = tbl_last_tx[k] + $urandom_range(1);
        end else if (pick < 90) begin
            ip = $urandom;
            if ($urandom_range(99) < 40) begin
                rx = $urandom_range(1);
                tx = $urandom_range(1);
            end else begin
                rx = $urandom;
                tx = $urandom;
            end
        end else begin
            ip = $urandom;
            rx = $urandom;
            tx = $urandom;
        end
    endtask

    // Ends at the falling edge after the handshake, with tvalid still high.
    task automatic offer_request(logic [DATA_W-1:0] ip, rx, tx, bit typed,
                                 t_client_rate typed_res);
        t_client_rate calc;
        int gap;
        if (src_idle_pct != 0) begin
            if ($urandom_range(7) == 0) begin
                gap = $urandom_range(1, 80);
                repeat (gap) begin
                    i_s_tvalid <= 1'b0;
                    @(negedge i_clk);
                end
            end else begin
                while ($urandom_range(99) < src_idle_pct) begin
                    i_s_tvalid <= 1'b0;
                    @(negedge i_clk);
                end
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {tx, rx, ip};
        do @(posedge i_clk); while (!o_s_tready);
        calc = rate_table_apply(ip, rx, tx);
        pending_rates.push_back(typed ? typed_res : calc);
        requests_sent++;
        @(negedge i_clk);
    endtask

    function automatic void check_field(string name, logic [DATA_W-1:0] want, got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_client_rate want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            outcome_seen[o_m_tuser]++;
            if (pending_rates.size() == 0) begin
                $display("%0t: result with no request outstanding, expected none, actual %0h",
                         $time, o_m_tdata);
                fail_count++;
            end else begin
                want = pending_rates.pop_front();
                check_field("slot", want.slot, o_m_tdata[SLOT_W-1:0]);
                check_field("outcome", want.outcome, o_m_tuser);
                check_field("rx_rate", want.rx_rate, o_m_tdata[RX_LO +: DATA_W]);
                check_field("tx_rate", want.tx_rate, o_m_tdata[TX_LO +: DATA_W]);
                check_field("client_count", want.count, o_m_tdata[CNT_LO +: COUNT_W]);
                check_field("padding", '0, o_m_tdata[OUT_TDATA_W-1:OUT_FIELD_W]);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles + 1 >= STALL_LIMIT) begin
            $display("%0t: timeout, no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin : result_sink
        int hold_taken;
        int hold_left;
        hold_taken = 0;
        hold_left = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_pending != hold_taken) begin
                hold_taken = hold_pending;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    initial begin : request_source
        t_stim_row row;
        t_client_rate blank;
        logic [DATA_W-1:0] ip, rx, tx;
        int fill_slot;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        blank = make_result(0, OC_DROP, 0, 0, 0);

        directed_rows.push_back(typed_row(32'h0, 32'h0, 32'h0, 0, OC_INSERT, 0, 0, 1));
        directed_rows.push_back(typed_row('1, '1, '1, 1, OC_INSERT,
                                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 2));
        directed_rows.push_back(typed_row('1, 32'd1, 32'd0, 1, OC_UPDATE,
                                          32'd1, 32'h7FFF_FFFF, 2));
        directed_rows.push_back(typed_row('1, 32'd0, 32'd5, 1, OC_UPDATE, 32'd1, 32'd3, 2));
        directed_rows.push_back(typed_row(32'h0, 32'd100, 32'd200, 0, OC_UPDATE,
                                          32'd50, 32'd100, 2));
        directed_rows.push_back(typed_row(32'h0, 32'd0, 32'd0, 0, OC_UPDATE,
                                          32'd50, 32'd100, 2));
        directed_rows.push_back(typed_row(32'h8000_0001, 32'd3, 32'hFFFF_FFFE, 2, OC_INSERT,
                                          32'd1, 32'h7FFF_FFFF, 3));
        row = plain_row(0, 0, 0);
        row.kind = ROW_FILL;
        directed_rows.push_back(row);
        directed_rows.push_back(typed_row(32'h1234_5678, 32'd2, 32'd0, 31, OC_REPLACE,
                                          32'd1, 32'd0, 32));
        directed_rows.push_back(typed_row(32'h2345_6789, 32'd1, 32'd1, 20, OC_REPLACE,
                                          32'd0, 32'd0, 32));
        directed_rows.push_back(typed_row(32'h3456_789A, 32'd10, 32'd20, 20, OC_REPLACE,
                                          32'd5, 32'd10, 32));
        directed_rows.push_back(typed_row(32'h4567_89AB, 32'd7, 32'd7, 0, OC_DROP, 0, 0, 32));
        directed_rows.push_back(typed_row(32'h0, 32'd100, 32'd200, 0, OC_UPDATE, 0, 0, 32));
        directed_rows.push_back(typed_row(32'h5678_9ABC, '1, 32'd0, 0, OC_REPLACE,
                                          32'h7FFF_FFFF, 32'd0, 32));
        directed_rows.push_back(typed_row(32'h0, 32'd0, 32'd0, 0, OC_DROP, 0, 0, 32));
        directed_rows.push_back(plain_row(32'h0A00_0005, 32'd1, 32'd1));
        directed_rows.push_back(plain_row(32'h1234_5678, '1, 32'h8000_0000));
        directed_rows.push_back(typed_row(32'h0A00_001F, 32'd9, 32'd9, 0, OC_DROP, 0, 0, 32));

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        src_idle_pct = 38;
        snk_stall_pct = 60;
        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            if (row.kind == ROW_FILL) begin
                // Slots 20 and the last one stay idle so the full table has room to replace.
                while (tbl_fill < MAX_CLIENTS) begin
                    fill_slot = tbl_fill;
                    if (fill_slot == 20 || fill_slot == MAX_CLIENTS - 1) begin
                        offer_request(32'h0A00_0000 | fill_slot, 32'd0, 32'd1, 1'b0, blank);
                    end else begin
                        offer_request(32'h0A00_0000 | fill_slot, fill_slot * 8 + 2,
                                      fill_slot * 12 + 3, 1'b0, blank);
                    end
                end
            end else begin
                offer_request(row.ip, row.rx, row.tx, row.typed, row.res);
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            i_s_tvalid <= 1'b0;
            while (pending_rates.size() != 0) @(negedge i_clk);
            case (phase)
                0: begin
                    src_idle_pct = 38;
                    snk_stall_pct = 60;
                end
                1: begin
                    src_idle_pct = 60;
                    snk_stall_pct = 38;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_stall_pct = 0;
                    hold_pending++;
                end
            endcase
            repeat (RANDOM_PER_PHASE) begin
                next_random_request(ip, rx, tx);
                offer_request(ip, rx, tx, 1'b0, blank);
            end
        end
        i_s_tvalid <= 1'b0;

        while (pending_rates.size() != 0) @(posedge i_clk);
        repeat (2 * MAX_CLIENTS + 40) @(posedge i_clk);

        $display("Sent %0d requests and checked %0d results: %0d updates, %0d inserts, ",
                 requests_sent, results_seen, outcome_seen[OC_UPDATE],
                 outcome_seen[OC_INSERT]);
        $display("%0d idle replacements, %0d drops, under gaps, stalls and a long hold-off.",
                 outcome_seen[OC_REPLACE], outcome_seen[OC_DROP]);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
